FILE: src/progressive_pixel_accumulate_gamma_defines.svh
// Assertion macros for the progressive pixel accumulator.
`ifndef PROGRESSIVE_PIXEL_ACCUMULATE_GAMMA_DEFINES_SVH
`define PROGRESSIVE_PIXEL_ACCUMULATE_GAMMA_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define PPAG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define PPAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ppag_pkg.sv
// ----------------------------------------------------------------------------
// ppag_pkg
// Types and constants shared by the progressive pixel accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ppag_pkg;

  localparam int unsigned MaxPixels = 65536;
  localparam int unsigned MaxSide   = 1024;
  localparam int unsigned FrameBits = 16;
  localparam int unsigned AddrW     = $clog2(MaxPixels);
  localparam int unsigned SumW      = 32;
  localparam int unsigned SumRowW   = 3 * SumW;
  localparam int unsigned CfgW      = 11;

  localparam logic [FrameBits-1:0] FrameMax = {FrameBits{1'b1}};

  // Configuration register indexes
  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] sample_red;
    logic [15:0] sample_green;
    logic [15:0] sample_blue;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [9:0] dest_x;
    logic [9:0] dest_y;
    logic [7:0] display_red;
    logic [7:0] display_green;
    logic [7:0] display_blue;
    logic       pixel_rejected;
  } out_item_t;

  typedef enum logic [7:0] {
    StClear = 8'b0000_0001,
    StIdle  = 8'b0000_0010,
    StRead  = 8'b0000_0100,
    StAdd   = 8'b0000_1000,
    StDiv   = 8'b0001_0000,
    StSqrt  = 8'b0010_0000,
    StNext  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

endpackage

FILE: src/ppag_ram.sv
// ----------------------------------------------------------------------------
// ppag_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppag_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Access one entry per cycle: write it when we_i is high, and always read it
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: src/progressive_pixel_accumulate_gamma.sv
// ----------------------------------------------------------------------------
// progressive_pixel_accumulate_gamma
// Per-pixel running RGB sums, averaged over frames and gamma-2 encoded.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// item in  | start, busy          | in_item_i (in_item_t)
// item out | result_valid_o       | result_o (out_item_t)
// config   | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// An accepted pixel keeps busy high through the read, add, divide, square-root,
// next and output states, the result strobe in the last; a rejected one goes
// straight to the output state. The rate is set by the shared restoring divider
// (32 steps per channel) and the shared square root (a load, 18 two-bit steps
// and a finish per channel). After reset a clearing pass zeroes the sum memory;
// busy stays high meanwhile. The result strobe lasts one cycle; no stall exists.
`timescale 1ns / 1ps
module progressive_pixel_accumulate_gamma
  import ppag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_item_i,
  output logic                result_valid_o,
  output out_item_t           result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

`include "progressive_pixel_accumulate_gamma_defines.svh"

  state_e state_q, state_d;
  logic [CfgW-1:0]      width_q, height_q;
  logic [FrameBits-1:0] frames_q;
  in_item_t             item_q;
  logic [AddrW:0]       clr_q;
  logic [AddrW-1:0]     addr_q;
  logic [1:0]           ch_q;
  logic [5:0]           step_q;
  logic [SumW-1:0]      sum_q [3];
  logic [SumW-1:0]      quo_q;
  logic [FrameBits:0]   rem_q;
  logic [SumW+3:0]      rad_q;   // 16*avg, 36 bits
  logic [17:0]          root_q;
  logic [19:0]          srem_q;
  logic [7:0]           disp_q [3];
  logic                 rej_q;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_addr;
  logic [SumRowW-1:0]   ram_wdata, ram_rdata;

  // Accept and reject decode
  logic            accept;
  logic [20:0]     idx;
  logic            reject;
  assign accept = start && !busy;
  assign idx = 21'(in_item_i.pixel_y) * 21'(width_q) + 21'(in_item_i.pixel_x);
  assign reject = (11'(in_item_i.pixel_x) >= width_q) ||
                  (11'(in_item_i.pixel_y) >= height_q) ||
                  (idx >= 21'(MaxPixels));

  assign busy = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(256);
      height_q <= CfgW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memory access
  logic [SumW:0] add_r, add_g, add_b;
  assign add_r = {1'b0, ram_rdata[3*SumW-1 -: SumW]} + 33'(item_q.sample_red);
  assign add_g = {1'b0, ram_rdata[2*SumW-1 -: SumW]} + 33'(item_q.sample_green);
  assign add_b = {1'b0, ram_rdata[SumW-1 -: SumW]} + 33'(item_q.sample_blue);

  logic [SumW-1:0] sat_r, sat_g, sat_b;
  assign sat_r = add_r[SumW] ? '1 : add_r[SumW-1:0];
  assign sat_g = add_g[SumW] ? '1 : add_g[SumW-1:0];
  assign sat_b = add_b[SumW] ? '1 : add_b[SumW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = {sat_r, sat_g, sat_b};
    if (state_q == StClear) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q[AddrW-1:0];
      ram_wdata = '0;
    end else if (state_q == StAdd) begin
      ram_we = 1'b1;
    end
  end

  ppag_ram #(.Width(SumRowW), .Depth(MaxPixels)) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Divider step: shift in one dividend bit, subtract frames+1
  logic [FrameBits:0]   divisor;
  logic [FrameBits+1:0] div_trial;
  logic [FrameBits+1:0] div_sub;
  assign divisor   = {1'b0, frames_q} + 17'd1;
  assign div_trial = {rem_q, quo_q[SumW-1]};
  assign div_sub   = div_trial - {1'b0, divisor};

  // Square-root step: two radicand bits per step
  logic [21:0] sq_trial;
  logic [21:0] sq_cmp;
  logic [21:0] sq_diff;
  assign sq_trial = {srem_q, rad_q[SumW+3 -: 2]};
  assign sq_cmp   = {2'b00, root_q, 2'b01};
  assign sq_diff  = sq_trial - sq_cmp;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == (AddrW+1)'(MaxPixels - 1)) state_d = StIdle;
      StIdle:  if (accept) state_d = reject ? StOut : StRead;
      StRead:  state_d = StAdd;
      StAdd:   state_d = StDiv;
      StDiv:   if (step_q == 6'd31) state_d = StSqrt;
      StSqrt:  if (step_q == 6'd19) state_d = (ch_q == 2'd2) ? StNext : StDiv;
      StNext:  state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      frames_q <= '0;
      step_q   <= '0;
      ch_q     <= '0;
      rej_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StClear: clr_q <= clr_q + 1'b1;
        StIdle: if (accept) begin
          rej_q <= reject;
          ch_q  <= '0;
        end
        StAdd: step_q <= '0;
        StDiv: step_q <= (step_q == 6'd31) ? 6'd0 : step_q + 6'd1;
        StSqrt: begin
          step_q <= (step_q == 6'd19) ? 6'd0 : step_q + 6'd1;
          if (step_q == 6'd19) ch_q <= ch_q + 2'd1;
        end
        StNext: if (item_q.frame_end && frames_q != FrameMax) frames_q <= frames_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (accept) begin
        item_q <= in_item_i;
        addr_q <= idx[AddrW-1:0];
        disp_q[0] <= '0; disp_q[1] <= '0; disp_q[2] <= '0;
      end
      StAdd: begin
        sum_q[0] <= sat_r; sum_q[1] <= sat_g; sum_q[2] <= sat_b;
        quo_q <= sat_r;
        rem_q <= '0;
      end
      StDiv: begin
        if (!div_sub[FrameBits+1]) begin
          rem_q <= div_sub[FrameBits:0];
          quo_q <= {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= div_trial[FrameBits:0];
          quo_q <= {quo_q[SumW-2:0], 1'b0};
        end
        if (step_q == 6'd31) begin
          root_q <= '0;
          srem_q <= '0;
        end
      end
      StSqrt: begin
        if (step_q == 6'd0) begin
          rad_q <= {quo_q, 4'b0};
        end
        if (step_q == 6'd19) begin
          disp_q[ch_q] <= (root_q > 18'd255) ? 8'd255 : root_q[7:0];
          if (ch_q != 2'd2) begin
            quo_q <= sum_q[ch_q + 2'd1];
            rem_q <= '0;
          end
        end
      end
      default: ;
    endcase
    // Square-root iterations on steps 1..18 (quotient loaded at step 0)
    if (state_q == StSqrt && step_q == 6'd0) begin
      root_q <= '0;
      srem_q <= '0;
    end else if (state_q == StSqrt && step_q != 6'd19) begin
      rad_q <= {rad_q[SumW+1:0], 2'b00};
      if (sq_trial >= sq_cmp) begin
        srem_q <= sq_diff[19:0];
        root_q <= {root_q[16:0], 1'b1};
      end else begin
        srem_q <= sq_trial[19:0];
        root_q <= {root_q[16:0], 1'b0};
      end
    end
  end

  // Result output
  assign result_valid_o          = (state_q == StOut);
  assign result_o.dest_x         = item_q.pixel_x;
  assign result_o.dest_y         = item_q.pixel_y;
  assign result_o.display_red    = rej_q ? 8'd0 : disp_q[0];
  assign result_o.display_green  = rej_q ? 8'd0 : disp_q[1];
  assign result_o.display_blue   = rej_q ? 8'd0 : disp_q[2];
  assign result_o.pixel_rejected = rej_q;

  `PPAG_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, busy,
    "busy low outside idle")
  `PPAG_ASSERT_NEXT(a_result_once, clk_i, rst_ni, result_valid_o, !result_valid_o,
    "result strobe longer than one cycle")
  `PPAG_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, accept, busy,
    "accepted item did not start work")

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the progressive pixel accumulator. A driver pushes
// samples from a pending queue and keeps its own copy of the per-pixel
// running sums and frame count. It predicts each display pixel, which a
// monitor then checks field by field. Image sizes are changed between phases
// while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import ppag_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainWait  = 20;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_item_t        in_item_i = '0;
  logic            result_valid_o;
  out_item_t       result_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [0:0]      cfg_index_i = RegWidth;
  logic [CfgW-1:0] cfg_data_i = '0;

  progressive_pixel_accumulate_gamma dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  bit [SumW-1:0]      acc_red   [MaxPixels];
  bit [SumW-1:0]      acc_green [MaxPixels];
  bit [SumW-1:0]      acc_blue  [MaxPixels];
  bit [FrameBits-1:0] frame_count = '0;
  bit [CfgW-1:0]      img_width  = 11'd256;
  bit [CfgW-1:0]      img_height = 11'd256;

  in_item_t  pending_samples[$];
  out_item_t expected_pixels[$];
  int        errors = 0;
  bit        calm = 1'b0;
  int unsigned cycles = 0;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [15:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  // Floor square root by bit-by-bit trial
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 18; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [7:0] gamma_level(input logic [SumW-1:0] sum);
    longint unsigned avg;
    longint unsigned r;
    avg = longint'(sum) / (longint'(frame_count) + 1);
    r = floor_sqrt(avg * 16);
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // Add one sample to the predictor and return its display pixel
  function automatic out_item_t accumulate_pixel(input in_item_t it);
    out_item_t       o;
    longint unsigned idx;
    logic [AddrW-1:0] a;
    idx = longint'(it.pixel_y) * img_width + it.pixel_x;
    o = '0;
    o.dest_x = it.pixel_x;
    o.dest_y = it.pixel_y;
    if (it.pixel_x >= img_width || it.pixel_y >= img_height ||
        it.pixel_x >= MaxSide || it.pixel_y >= MaxSide || idx >= MaxPixels) begin
      o.pixel_rejected = 1'b1;
      return o;
    end
    a = idx[AddrW-1:0];
    acc_red[a]   = sat_add(acc_red[a], it.sample_red);
    acc_green[a] = sat_add(acc_green[a], it.sample_green);
    acc_blue[a]  = sat_add(acc_blue[a], it.sample_blue);
    o.display_red   = gamma_level(acc_red[a]);
    o.display_green = gamma_level(acc_green[a]);
    o.display_blue  = gamma_level(acc_blue[a]);
    if (it.frame_end && frame_count != FrameMax) frame_count++;
    return o;
  endfunction

  // Driver: predict on accept, then load the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      in_item_i <= '0;
    end else begin
      if (start && !busy) expected_pixels.push_back(accumulate_pixel(in_item_i));
      if (!start || !busy) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          start     <= 1'b1;
          in_item_i <= pending_samples.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", result_o.dest_x, result_o.dest_y);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (result_o.dest_x !== e.dest_x) begin
          $error("dest_x exp %0d got %0d", e.dest_x, result_o.dest_x); errors++;
        end
        if (result_o.dest_y !== e.dest_y) begin
          $error("dest_y exp %0d got %0d", e.dest_y, result_o.dest_y); errors++;
        end
        if (result_o.display_red !== e.display_red) begin
          $error("display_red exp %0d got %0d", e.display_red, result_o.display_red);
          errors++;
        end
        if (result_o.display_green !== e.display_green) begin
          $error("display_green exp %0d got %0d", e.display_green, result_o.display_green);
          errors++;
        end
        if (result_o.display_blue !== e.display_blue) begin
          $error("display_blue exp %0d got %0d", e.display_blue, result_o.display_blue);
          errors++;
        end
        if (result_o.pixel_rejected !== e.pixel_rejected) begin
          $error("pixel_rejected exp %0d got %0d", e.pixel_rejected,
                 result_o.pixel_rejected);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] index, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == RegWidth) img_width = value;
    else img_height = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || start || expected_pixels.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Mostly in-image samples, clustered on a few pixels so sums grow
  function automatic in_item_t rand_sample_item(input int unsigned w, input int unsigned h);
    in_item_t    it;
    int unsigned xs;
    int unsigned ys;
    int unsigned r;
    xs = (w > MaxSide) ? MaxSide : w;
    ys = (h > MaxSide) ? MaxSide : h;
    r  = $urandom_range(0, 99);
    it.pixel_x = 10'($urandom_range(0, 1023));
    it.pixel_y = 10'($urandom_range(0, 1023));
    if (xs != 0 && ys != 0 && r < 55) begin
      it.pixel_x = 10'($urandom_range(0, ((xs < 6) ? xs : 6) - 1));
      it.pixel_y = 10'($urandom_range(0, ((ys < 6) ? ys : 6) - 1));
    end else if (xs != 0 && ys != 0 && r < 88) begin
      it.pixel_x = 10'($urandom_range(0, xs - 1));
      it.pixel_y = 10'($urandom_range(0, ys - 1));
    end
    it.sample_red   = rand_sample();
    it.sample_green = rand_sample();
    it.sample_blue  = rand_sample();
    it.frame_end    = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  initial begin
    int unsigned ph_w[10] = '{0, 1, 1024, 2047, 7, 1024, 100, 37, 2047, 256};
    int unsigned ph_h[10] = '{5, 1, 1024, 2047, 3, 64, 700, 11, 1, 256};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, saturating samples, frame marks, out-of-image pixels
    write_reg(RegWidth, 11'd256);
    write_reg(RegHeight, 11'd256);
    pending_samples.push_back('{10'd0, 10'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    pending_samples.push_back('{10'd255, 10'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
    pending_samples.push_back('{10'd0, 10'd0, 16'hFFFF, 16'h0001, 16'h1000, 1'b1});
    pending_samples.push_back('{10'd0, 10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
    pending_samples.push_back('{10'd256, 10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
    pending_samples.push_back('{10'd0, 10'd256, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1});
    pending_samples.push_back('{10'd1023, 10'd1023, 16'h5555, 16'hAAAA, 16'h5555, 1'b1});
    pending_samples.push_back('{10'h2AA, 10'h155, 16'h1234, 16'h8000, 16'h7FFF, 1'b0});
    pending_samples.push_back('{10'd170, 10'd85, 16'hAAAA, 16'h5555, 16'h0FFF, 1'b1});
    pending_samples.push_back('{10'd85, 10'd170, 16'h5555, 16'hAAAA, 16'hF000, 1'b0});
    pending_samples.push_back('{10'd0, 10'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1});
    pending_samples.push_back('{10'd255, 10'd255, 16'hFFFF, 16'h0000, 16'h8000, 1'b0});
    drain();

    // Random phases across image sizes, one without idling
    for (int p = 0; p < 10; p++) begin
      write_reg(RegWidth, CfgW'(ph_w[p]));
      write_reg(RegHeight, CfgW'(ph_h[p]));
      calm = (p == 3);
      for (int i = 0; i < 165; i++) pending_samples.push_back(rand_sample_item(ph_w[p], ph_h[p]));
      drain();
    end

    if (expected_pixels.size() != 0) begin
      $error("%0d results never arrived", expected_pixels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
